FILE: hw/rtl/tmss_pkg.sv
// Shared types, codes and reset values for the two-motor scan sequencer.
package tmss_pkg;

  // Sequencer modes, also the value of the result's mode field
  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ASCEND = 3'd1,
    MODE_ROTATE = 3'd2,
    MODE_LIFT   = 3'd3,
    MODE_HOME   = 3'd4
  } mode_t;

  // Events: the input op codes plus the internal lift phase timer expiry
  typedef enum logic [3:0] {
    EV_START1 = 4'd0,
    EV_START2 = 4'd1,
    EV_LOWER  = 4'd2,
    EV_UPPER  = 4'd3,
    EV_PULSE  = 4'd4,
    EV_STOP   = 4'd5,
    EV_RESET  = 4'd6,
    EV_TICK   = 4'd7,
    EV_TIMER  = 4'd8
  } event_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SCAN_LIFT_RATE    = 3'd0;
  localparam logic [2:0] CFG_FAST_LIFT_RATE    = 3'd1;
  localparam logic [2:0] CFG_FAST_TURN_RATE    = 3'd2;
  localparam logic [2:0] CFG_MEDIUM_TURN_RATE  = 3'd3;
  localparam logic [2:0] CFG_SLOW_TURN_RATE    = 3'd4;
  localparam logic [2:0] CFG_LIFT_PHASE_MS     = 3'd5;
  localparam logic [2:0] CFG_MAX_QUARTER_STEPS = 3'd6;

  // Configuration reset values
  localparam logic [15:0] RST_SCAN_LIFT_RATE    = 16'd400;
  localparam logic [15:0] RST_FAST_LIFT_RATE    = 16'd4800;
  localparam logic [15:0] RST_FAST_TURN_RATE    = 16'd12800;
  localparam logic [15:0] RST_MEDIUM_TURN_RATE  = 16'd8533;
  localparam logic [15:0] RST_SLOW_TURN_RATE    = 16'd3413;
  localparam logic [15:0] RST_LIFT_PHASE_MS     = 16'd3333;
  localparam logic [2:0]  RST_MAX_QUARTER_STEPS = 3'd3;

  typedef struct packed {
    logic [15:0] scan_lift_rate;
    logic [15:0] fast_lift_rate;
    logic [15:0] fast_turn_rate;
    logic [15:0] medium_turn_rate;
    logic [15:0] slow_turn_rate;
    logic [15:0] lift_phase_ms;
    logic [2:0]  max_quarter_steps;
  } cfg_t;

  typedef struct packed {
    logic lower;
    logic upper;
    logic zero;
  } switches_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  quarter_count;
    logic [15:0] phase_timer;
    logic        timer_armed;
    logic [15:0] lift_rate;
    logic        lift_en;
    logic        lift_down;
    logic [15:0] turn_rate;
    logic        turn_en;
    logic        turn_left;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    mode:          MODE_OFF,
    quarter_count: 3'd0,
    phase_timer:   16'd0,
    timer_armed:   1'b0,
    lift_rate:     16'd0,
    lift_en:       1'b0,
    lift_down:     1'b0,
    turn_rate:     16'd0,
    turn_en:       1'b0,
    turn_left:     1'b0
  };

endpackage

FILE: hw/rtl/tmss_step.sv
// Next-state logic of the scan sequencer for one event.
module tmss_step import tmss_pkg::*; (
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  logic [2:0] op,
  input  switches_t  sw,
  output seq_state_t nxt,
  output logic       beep
);

  event_t      ev;
  logic [3:0]  quarter_sum;
  logic [15:0] timer_inc;

  always_comb begin
    ev          = event_t'({1'b0, op});
    nxt         = cur;
    beep        = 1'b0;
    quarter_sum = {1'b0, cur.quarter_count} + 4'd1;
    timer_inc   = (cur.phase_timer == 16'hFFFF) ? cur.phase_timer
                                                : cur.phase_timer + 16'd1;

    // Ticks only advance the armed timer; expiry turns into a timer event
    if (ev == EV_TICK && cur.timer_armed) begin
      nxt.phase_timer = timer_inc;
      if (timer_inc >= cfg.lift_phase_ms) begin
        nxt.timer_armed = 1'b0;
        ev              = EV_TIMER;
      end
    end

    unique case (cur.mode)
      MODE_OFF: begin
        if (ev == EV_START1 || ev == EV_START2) begin
          if (!sw.lower) begin
            beep = 1'b1;
          end else if (ev == EV_START1) begin
            nxt.turn_rate = cfg.medium_turn_rate;
            nxt.turn_en   = 1'b1;
            nxt.turn_left = 1'b1;
            nxt.lift_rate = cfg.scan_lift_rate;
            nxt.lift_en   = 1'b1;
            nxt.lift_down = 1'b0;
            nxt.mode      = MODE_ASCEND;
          end else begin
            nxt.quarter_count = 3'd0;
            nxt.turn_rate     = cfg.slow_turn_rate;
            nxt.turn_en       = 1'b1;
            nxt.turn_left     = 1'b1;
            nxt.lift_rate     = 16'd0;
            nxt.lift_en       = 1'b1;
            nxt.mode          = MODE_ROTATE;
          end
        end
      end
      MODE_ASCEND, MODE_ROTATE, MODE_LIFT: begin
        if (ev == EV_STOP) begin
          nxt.turn_rate = 16'd0;
          nxt.turn_en   = 1'b0;
          nxt.lift_rate = 16'd0;
          nxt.lift_en   = 1'b0;
          nxt.mode      = MODE_OFF;
        end else if ((cur.mode == MODE_ASCEND && ev == EV_UPPER) ||
                     (cur.mode == MODE_ROTATE && ev == EV_PULSE &&
                      (quarter_sum > {1'b0, cfg.max_quarter_steps} || sw.upper))) begin
          nxt.lift_rate = cfg.fast_lift_rate;
          nxt.lift_en   = 1'b1;
          nxt.lift_down = 1'b1;
          nxt.turn_rate = cfg.fast_turn_rate;
          nxt.turn_en   = 1'b1;
          nxt.turn_left = 1'b1;
          nxt.mode      = MODE_HOME;
        end else if (cur.mode == MODE_ROTATE && ev == EV_PULSE) begin
          // Quarter turn done: stop turning and start a timed lift phase
          nxt.turn_rate   = 16'd0;
          nxt.turn_en     = 1'b0;
          nxt.lift_rate   = cfg.fast_lift_rate;
          nxt.lift_en     = 1'b1;
          nxt.lift_down   = 1'b0;
          nxt.phase_timer = 16'd0;
          nxt.timer_armed = 1'b1;
          nxt.mode        = MODE_LIFT;
        end else if (cur.mode == MODE_LIFT && (ev == EV_UPPER || ev == EV_TIMER)) begin
          nxt.turn_rate = cfg.slow_turn_rate;
          nxt.turn_en   = 1'b1;
          nxt.turn_left = 1'b1;
          nxt.lift_rate = 16'd0;
          nxt.lift_en   = 1'b1;
          nxt.mode      = MODE_ROTATE;
        end
        if (cur.mode == MODE_ROTATE && ev == EV_PULSE) begin
          nxt.quarter_count = quarter_sum[3] ? 3'd7 : quarter_sum[2:0];
        end
      end
      MODE_HOME: begin
        if (ev == EV_UPPER || ev == EV_LOWER) begin
          nxt.lift_rate = 16'd0;
          nxt.lift_en   = 1'b0;
          if (!cur.turn_en) begin
            nxt.mode = MODE_OFF;
          end
        end else if (ev == EV_STOP) begin
          nxt.turn_rate = 16'd0;
          nxt.turn_en   = 1'b0;
          nxt.lift_rate = 16'd0;
          nxt.lift_en   = 1'b0;
          nxt.mode      = MODE_OFF;
        end else if (ev == EV_PULSE) begin
          nxt.turn_rate = 16'd0;
          nxt.turn_en   = 1'b0;
          if (!cur.lift_en) begin
            nxt.mode = MODE_OFF;
          end
        end
      end
      default: begin
      end
    endcase

    // Reset event outside homing: start only the motors away from home
    if (ev == EV_RESET && cur.mode != MODE_HOME) begin
      if (!sw.lower) begin
        nxt.lift_rate = cfg.fast_lift_rate;
        nxt.lift_en   = 1'b1;
        nxt.lift_down = 1'b1;
        nxt.mode      = MODE_HOME;
      end
      if (!sw.zero) begin
        nxt.turn_rate = cfg.fast_turn_rate;
        nxt.turn_en   = 1'b1;
        nxt.turn_left = 1'b1;
        nxt.mode      = MODE_HOME;
      end
    end
  end

endmodule

FILE: hw/rtl/two_motor_scan_sequencer.sv
// Top level of the two-motor scan sequencer: handshakes, registers and config.
// Path: an accepted event item is held in the input register, then its state
//   update lands in the result register.
// Throughput: one event item per cycle; back-to-back items flow when the
//   result side keeps taking them, set by the combinational next-state logic.
// Reset (rst, synchronous): mode off, both motors disabled with rate 0,
//   timer disarmed, config registers back to their defaults, no item held.
module two_motor_scan_sequencer import tmss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Event side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] lower_switch, [1] upper_switch, [2] zero_switch
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  // Result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [2:0] mode, [18:3] lift_rate, [19] lift_enabled,
                                      // [20] lift_down, [36:21] turn_rate, [37] turn_enabled,
                                      // [38] turn_left, [39] beep, [40] changed
  // Configuration writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Input register
  logic       in_valid;
  logic [2:0] in_op;
  switches_t  in_sw;

  // Sequencer state and configuration
  seq_state_t state;
  seq_state_t state_next;
  logic       beep_next;
  cfg_t       cfg;

  // Result register
  logic        out_valid;
  logic [40:0] out_data;

  logic advance;

  // Process the held event when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Capture the event payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op <= s_axis_tuser;
      in_sw <= '{lower: s_axis_tdata[0], upper: s_axis_tdata[1], zero: s_axis_tdata[2]};
    end
  end

  // Configuration registers; the user writes them only while the block is idle, unenforced
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_lift_rate    <= RST_SCAN_LIFT_RATE;
      cfg.fast_lift_rate    <= RST_FAST_LIFT_RATE;
      cfg.fast_turn_rate    <= RST_FAST_TURN_RATE;
      cfg.medium_turn_rate  <= RST_MEDIUM_TURN_RATE;
      cfg.slow_turn_rate    <= RST_SLOW_TURN_RATE;
      cfg.lift_phase_ms     <= RST_LIFT_PHASE_MS;
      cfg.max_quarter_steps <= RST_MAX_QUARTER_STEPS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCAN_LIFT_RATE:    cfg.scan_lift_rate    <= cfg_data;
        CFG_FAST_LIFT_RATE:    cfg.fast_lift_rate    <= cfg_data;
        CFG_FAST_TURN_RATE:    cfg.fast_turn_rate    <= cfg_data;
        CFG_MEDIUM_TURN_RATE:  cfg.medium_turn_rate  <= cfg_data;
        CFG_SLOW_TURN_RATE:    cfg.slow_turn_rate    <= cfg_data;
        CFG_LIFT_PHASE_MS:     cfg.lift_phase_ms     <= cfg_data;
        CFG_MAX_QUARTER_STEPS: cfg.max_quarter_steps <= cfg_data[2:0];
        default: begin
          // Drop writes to unused indexes
        end
      endcase
    end
  end

  tmss_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .op   (in_op),
    .sw   (in_sw),
    .nxt  (state_next),
    .beep (beep_next)
  );

  // Advance the sequencer state once per processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold until taken, refill in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {state_next.mode != state.mode, beep_next,
                   state_next.turn_left, state_next.turn_en, state_next.turn_rate,
                   state_next.lift_down, state_next.lift_en, state_next.lift_rate,
                   state_next.mode};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_data};

  // A lift phase always runs on an armed timer
  a_lift_armed: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_LIFT |-> state.timer_armed)
    else $error("lift phase without armed timer");

  // Rotating phases turn left with the lift held in place
  a_rotate_hold: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_ROTATE |-> state.lift_en && state.lift_rate == 16'd0 &&
                                  state.turn_en && state.turn_left)
    else $error("rotating phase with lift not held");

  // Off means both drivers are disabled
  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_OFF |-> !state.lift_en && !state.turn_en)
    else $error("motor enabled while off");

  // A refused start never changes the mode
  a_beep_nochange: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_data[39] |-> !out_data[40])
    else $error("beep reported with a mode change");

endmodule

FILE: bench/scan_sequencer_checker.sv
`timescale 1ns / 1ps
// Checker for the scan sequencer: mirrors the mode machine and compares every result item.
module scan_sequencer_checker import tmss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] lower_switch, [1] upper_switch, [2] zero_switch
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [2:0] mode, [18:3] lift_rate, [19] lift_enabled,
                                      // [20] lift_down, [36:21] turn_rate, [37] turn_enabled,
                                      // [38] turn_left, [39] beep, [40] changed
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    mode_t       mode;
    logic [15:0] lift_rate;
    logic        lift_en;
    logic        lift_down;
    logic [15:0] turn_rate;
    logic        turn_en;
    logic        turn_left;
    logic        beep;
    logic        changed;
  } motor_out_t;

  motor_out_t motor_outputs_due[$];
  motor_out_t predicted;
  motor_out_t oldest;
  seq_state_t mirror;
  cfg_t       regs;
  logic       mode_move;
  mode_t      mode_next;
  mode_t      mode_prior;
  logic       beep_now;
  event_t     ev_in;
  switches_t  sw_in;

  task automatic enter_mode(input mode_t m);
    mode_move = 1'b1;
    mode_next = m;
  endtask

  task automatic drive_lift(input logic [15:0] rate, input logic down);
    mirror.lift_rate = rate;
    mirror.lift_en   = 1'b1;
    mirror.lift_down = down;
  endtask

  task automatic hold_lift();
    mirror.lift_rate = '0;
    mirror.lift_en   = 1'b1;
  endtask

  task automatic stop_lift();
    mirror.lift_rate = '0;
    mirror.lift_en   = 1'b0;
  endtask

  task automatic spin_left(input logic [15:0] rate);
    mirror.turn_rate = rate;
    mirror.turn_en   = 1'b1;
    mirror.turn_left = 1'b1;
  endtask

  task automatic stop_turn();
    mirror.turn_rate = '0;
    mirror.turn_en   = 1'b0;
  endtask

  task automatic halt_all();
    stop_turn();
    stop_lift();
    enter_mode(MODE_OFF);
  endtask

  task automatic head_home();
    drive_lift(regs.fast_lift_rate, 1'b1);
    spin_left(regs.fast_turn_rate);
    enter_mode(MODE_HOME);
  endtask

  // start only the motors that are not already home
  task automatic seek_home(input switches_t sw);
    if (!sw.lower) begin
      drive_lift(regs.fast_lift_rate, 1'b1);
      enter_mode(MODE_HOME);
    end
    if (!sw.zero) begin
      spin_left(regs.fast_turn_rate);
      enter_mode(MODE_HOME);
    end
  endtask

  task automatic react(input event_t ev, input switches_t sw);
    logic [3:0] turns;
    case (mirror.mode)
      MODE_OFF: begin
        if (ev == EV_START1 || ev == EV_START2) begin
          if (!sw.lower) begin
            beep_now = 1'b1;
          end else if (ev == EV_START1) begin
            spin_left(regs.medium_turn_rate);
            drive_lift(regs.scan_lift_rate, 1'b0);
            enter_mode(MODE_ASCEND);
          end else begin
            mirror.quarter_count = '0;
            spin_left(regs.slow_turn_rate);
            hold_lift();
            enter_mode(MODE_ROTATE);
          end
        end else if (ev == EV_RESET) begin
          seek_home(sw);
        end
      end
      MODE_ASCEND: begin
        if (ev == EV_STOP) halt_all();
        else if (ev == EV_UPPER) head_home();
        else if (ev == EV_RESET) seek_home(sw);
      end
      MODE_ROTATE: begin
        if (ev == EV_STOP) begin
          halt_all();
        end else if (ev == EV_RESET) begin
          seek_home(sw);
        end else if (ev == EV_PULSE) begin
          // compare the unsaturated count, store it saturated at 7
          turns = {1'b0, mirror.quarter_count} + 4'd1;
          mirror.quarter_count = (turns > 4'd7) ? 3'd7 : turns[2:0];
          if (turns > {1'b0, regs.max_quarter_steps} || sw.upper) begin
            head_home();
          end else begin
            stop_turn();
            drive_lift(regs.fast_lift_rate, 1'b0);
            mirror.phase_timer = '0;
            mirror.timer_armed = 1'b1;
            enter_mode(MODE_LIFT);
          end
        end
      end
      MODE_LIFT: begin
        if (ev == EV_STOP) begin
          halt_all();
        end else if (ev == EV_RESET) begin
          seek_home(sw);
        end else if (ev == EV_UPPER || ev == EV_TIMER) begin
          spin_left(regs.slow_turn_rate);
          hold_lift();
          enter_mode(MODE_ROTATE);
        end
      end
      MODE_HOME: begin
        if (ev == EV_UPPER || ev == EV_LOWER) begin
          stop_lift();
          if (!mirror.turn_en) enter_mode(MODE_OFF);
        end else if (ev == EV_STOP) begin
          halt_all();
        end else if (ev == EV_PULSE) begin
          stop_turn();
          if (!mirror.lift_en) enter_mode(MODE_OFF);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mirror = STATE_RESET;
      regs = '{scan_lift_rate:    RST_SCAN_LIFT_RATE,
               fast_lift_rate:    RST_FAST_LIFT_RATE,
               fast_turn_rate:    RST_FAST_TURN_RATE,
               medium_turn_rate:  RST_MEDIUM_TURN_RATE,
               slow_turn_rate:    RST_SLOW_TURN_RATE,
               lift_phase_ms:     RST_LIFT_PHASE_MS,
               max_quarter_steps: RST_MAX_QUARTER_STEPS};
      motor_outputs_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SCAN_LIFT_RATE:    regs.scan_lift_rate    = cfg_data;
          CFG_FAST_LIFT_RATE:    regs.fast_lift_rate    = cfg_data;
          CFG_FAST_TURN_RATE:    regs.fast_turn_rate    = cfg_data;
          CFG_MEDIUM_TURN_RATE:  regs.medium_turn_rate  = cfg_data;
          CFG_SLOW_TURN_RATE:    regs.slow_turn_rate    = cfg_data;
          CFG_LIFT_PHASE_MS:     regs.lift_phase_ms     = cfg_data;
          CFG_MAX_QUARTER_STEPS: regs.max_quarter_steps = cfg_data[2:0];
          default: ;
        endcase
      end

      // check before predicting so a result can never match its own event
      if (m_axis_tvalid && m_axis_tready) begin
        if (motor_outputs_due.size() == 0) begin
          $error("result item arrived with no event item waiting");
          mismatches++;
        end else begin
          oldest = motor_outputs_due.pop_front();
          compare_field("mode", oldest.mode, m_axis_tdata[2:0]);
          compare_field("lift_rate", oldest.lift_rate, m_axis_tdata[18:3]);
          compare_field("lift_enabled", oldest.lift_en, m_axis_tdata[19]);
          compare_field("lift_down", oldest.lift_down, m_axis_tdata[20]);
          compare_field("turn_rate", oldest.turn_rate, m_axis_tdata[36:21]);
          compare_field("turn_enabled", oldest.turn_en, m_axis_tdata[37]);
          compare_field("turn_left", oldest.turn_left, m_axis_tdata[38]);
          compare_field("beep", oldest.beep, m_axis_tdata[39]);
          compare_field("changed", oldest.changed, m_axis_tdata[40]);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        ev_in       = event_t'({1'b0, s_axis_tuser});
        sw_in.lower = s_axis_tdata[0];
        sw_in.upper = s_axis_tdata[1];
        sw_in.zero  = s_axis_tdata[2];
        mode_prior  = mirror.mode;
        mode_move   = 1'b0;
        beep_now    = 1'b0;
        if (ev_in == EV_TICK) begin
          // one-shot phase timer: a zero length fires on the first tick
          if (mirror.timer_armed) begin
            if (mirror.phase_timer != 16'hFFFF) mirror.phase_timer++;
            if (mirror.phase_timer >= regs.lift_phase_ms) begin
              mirror.timer_armed = 1'b0;
              react(EV_TIMER, sw_in);
            end
          end
        end else begin
          react(ev_in, sw_in);
        end
        if (mode_move) mirror.mode = mode_next;
        predicted.mode      = mirror.mode;
        predicted.lift_rate = mirror.lift_rate;
        predicted.lift_en   = mirror.lift_en;
        predicted.lift_down = mirror.lift_down;
        predicted.turn_rate = mirror.turn_rate;
        predicted.turn_en   = mirror.turn_en;
        predicted.turn_left = mirror.turn_left;
        predicted.beep      = beep_now;
        predicted.changed   = (mirror.mode != mode_prior);
        motor_outputs_due.push_back(predicted);
      end
    end
    outstanding = motor_outputs_due.size();
  end

endmodule

FILE: bench/tb_two_motor_scan_sequencer.sv
`timescale 1ns / 1ps
// Top of the scan sequencer bench: clock, reset, event and config stimulus, verdict.
module tb_two_motor_scan_sequencer import tmss_pkg::*; ();

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] lower_switch, [1] upper_switch, [2] zero_switch
  logic [2:0]  s_axis_tuser;   // [2:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [2:0] mode, [18:3] lift_rate, [19] lift_enabled,
                               // [20] lift_down, [36:21] turn_rate, [37] turn_enabled,
                               // [38] turn_left, [39] beep, [40] changed
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int   mismatches;
  int   outstanding;
  int   scored = 0;        // event items counted toward the per-phase quota
  int   tx_gap_pct = 0;    // chance of a gap burst before an event item
  int   rx_stall_pct = 0;  // chance of a stall burst on the result side
  int   stall_left = 0;
  int   phase_ms = 3333;   // current lift phase length, sizes the tick bursts
  cfg_t setting;

  two_motor_scan_sequencer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  scan_sequencer_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_two_motor_scan_sequencer failed");
    $finish;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Result side: take items, with random stall bursts when enabled.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (chance(rx_stall_pct)) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one event item and hold it until accepted. Called and returns at a
  // rising edge; tready is looked at mid-cycle so the accept edge is known.
  task automatic send_item(input event_t ev, input logic lo, input logic up,
                           input logic zr);
    if (chance(tx_gap_pct)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev[2:0];
    s_axis_tdata  <= {5'd0, zr, up, lo};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    scored++;
  endtask

  // Any op with any switch levels; not counted toward the quota.
  task automatic noise_item();
    send_item(event_t'(4'($urandom_range(0, 7))), coin(), coin(), coin());
    scored--;
  endtask

  // Drop valid and hold until every expected result item is back, then let
  // the pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write all seven registers back to back; only call while drained.
  task automatic load_settings(input cfg_t c);
    put_reg(CFG_SCAN_LIFT_RATE, c.scan_lift_rate);
    put_reg(CFG_FAST_LIFT_RATE, c.fast_lift_rate);
    put_reg(CFG_FAST_TURN_RATE, c.fast_turn_rate);
    put_reg(CFG_MEDIUM_TURN_RATE, c.medium_turn_rate);
    put_reg(CFG_SLOW_TURN_RATE, c.slow_turn_rate);
    put_reg(CFG_LIFT_PHASE_MS, c.lift_phase_ms);
    put_reg(CFG_MAX_QUARTER_STEPS, {13'd0, c.max_quarter_steps});
    cfg_write <= 1'b0;
    phase_ms = int'(c.lift_phase_ms);
  endtask

  // Bring a homing run to its end: lift limit and rotation pulse in either
  // order, or abort with stop now and then.
  task automatic finish_homing();
    if (chance(10)) begin
      send_item(EV_STOP, coin(), coin(), coin());
    end else if (chance(50)) begin
      send_item(EV_LOWER, 1'b1, 1'b0, coin());
      send_item(EV_PULSE, 1'b1, 1'b0, 1'b1);
    end else begin
      send_item(EV_PULSE, 1'b0, 1'b0, 1'b1);
      send_item(chance(80) ? EV_LOWER : EV_UPPER, 1'b1, 1'b0, 1'b1);
    end
  endtask

  // Stepwise scan: rotate, lift for a timed phase (or up to the limit), repeat
  // until the quarter count or the upper switch sends it home, or stop or reset ends it.
  task automatic stepwise_run();
    int turns;
    int ticks;
    send_item(EV_START2, chance(90), 1'b0, coin());
    turns = $urandom_range(0, 9);
    for (int k = 0; k < turns; k++) begin
      if (chance(8)) noise_item();
      send_item(EV_PULSE, 1'b0, chance(10), coin());
      ticks = $urandom_range(0, (phase_ms > 20) ? 24 : phase_ms + 2);
      repeat (ticks) send_item(EV_TICK, 1'b0, 1'b0, coin());
      if (chance(50)) send_item(EV_UPPER, 1'b0, 1'b1, coin());
      if (chance(5)) begin
        send_item(chance(50) ? EV_STOP : EV_RESET, coin(), coin(), coin());
        break;
      end
    end
    finish_homing();
  endtask

  // Continuous ascent: start, a few events it should ignore, then end it at
  // the upper limit, by stop or by reset.
  task automatic ascent_run();
    int roll;
    send_item(EV_START1, chance(90), 1'b0, coin());
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 4))
        0: send_item(EV_TICK, 1'b0, 1'b0, coin());
        1: send_item(EV_PULSE, 1'b0, 1'b0, coin());
        2: send_item(EV_LOWER, coin(), 1'b0, coin());
        3: send_item(EV_START1, coin(), 1'b0, coin());
        default: send_item(EV_START2, coin(), 1'b0, coin());
      endcase
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) send_item(EV_UPPER, 1'b0, 1'b1, coin());
    else if (roll < 85) send_item(EV_STOP, coin(), coin(), coin());
    else send_item(EV_RESET, coin(), coin(), coin());
    finish_homing();
  endtask

  initial begin
    int roll;
    logic last_phase;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings (three quarter turns allowed).
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    send_item(EV_START1, 1'b0, 1'b0, 1'b0);   // refused away from lower limit
    send_item(EV_START2, 1'b0, 1'b1, 1'b1);   // refused too
    send_item(EV_RESET, 1'b1, 1'b0, 1'b1);    // already home: nothing moves
    send_item(EV_TICK, 1'b1, 1'b0, 1'b1);
    send_item(EV_START1, 1'b1, 1'b0, 1'b0);   // continuous ascent
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b1);    // ignored while ascending
    send_item(EV_UPPER, 1'b0, 1'b1, 1'b0);    // go home
    send_item(EV_LOWER, 1'b1, 1'b0, 1'b0);    // lift stops, rotation still on
    send_item(EV_PULSE, 1'b1, 1'b0, 1'b1);    // both stopped: off
    send_item(EV_START2, 1'b1, 1'b0, 1'b0);   // stepwise
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b0);    // first quarter: lift phase
    send_item(EV_UPPER, 1'b0, 1'b1, 1'b0);
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b0);
    send_item(EV_UPPER, 1'b0, 1'b1, 1'b0);
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b0);
    send_item(EV_UPPER, 1'b0, 1'b1, 1'b0);
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b0);    // one quarter too many: home
    send_item(EV_PULSE, 1'b0, 1'b0, 1'b1);
    send_item(EV_LOWER, 1'b1, 1'b0, 1'b1);
    send_item(EV_RESET, 1'b0, 1'b0, 1'b1);    // only the lift is away
    send_item(EV_LOWER, 1'b1, 1'b0, 1'b1);
    send_item(EV_RESET, 1'b1, 1'b0, 1'b0);    // only the rotation is away
    send_item(EV_PULSE, 1'b1, 1'b0, 1'b1);
    send_item(EV_START2, 1'b1, 1'b0, 1'b1);
    send_item(EV_PULSE, 1'b0, 1'b1, 1'b0);    // upper switch on the pulse: home
    send_item(EV_STOP, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // Random part: eight settings, extremes first; the last phase runs
    // without any idling on either side.
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        setting = '0;
      end else if (p == 1) begin
        setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7};
      end else begin
        setting.scan_lift_rate    = 16'($urandom_range(0, 65535));
        setting.fast_lift_rate    = 16'($urandom_range(0, 65535));
        setting.fast_turn_rate    = 16'($urandom_range(0, 65535));
        setting.medium_turn_rate  = 16'($urandom_range(0, 65535));
        setting.slow_turn_rate    = 16'($urandom_range(0, 65535));
        setting.lift_phase_ms     = 16'($urandom_range(1, 12));
        setting.max_quarter_steps = 3'($urandom_range(0, 7));
      end
      last_phase = (p == 7);
      // quiet both sides early so any stall burst ends during the writes
      if (last_phase) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      load_settings(setting);
      scored = 0;
      while (scored < 212) begin
        // idle settings change per sequence so quiet stretches occur too
        if (last_phase || chance(25)) begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end else begin
          tx_gap_pct   = 30;
          rx_stall_pct = 30;
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) stepwise_run();
        else if (roll < 65) ascent_run();
        else if (roll < 80) begin
          send_item(EV_RESET, coin(), coin(), coin());
          finish_homing();
        end else begin
          repeat ($urandom_range(1, 4)) noise_item();
        end
        // occasionally starve the block until every result is back
        if (!last_phase && chance(4)) wait_drained();
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_two_motor_scan_sequencer passed");
    end else begin
      $display("tb_two_motor_scan_sequencer failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tmss_pkg.sv
hw/rtl/tmss_step.sv
hw/rtl/two_motor_scan_sequencer.sv
bench/scan_sequencer_checker.sv
bench/tb_two_motor_scan_sequencer.sv
